// File: rtl/ucp_pkg.sv
// Package for the URI character parser: phase and boundary-mark codes,
// character constants and the character-class functions.
// Used by ucp_step and uri_char_parser; depends on nothing.
package ucp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned PosW   = 12;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned MarkW  = 4;
  localparam int unsigned MaxUriLenDefault = 4096;

  localparam logic [CharW-1:0] ChSlash    = 8'h2F;
  localparam logic [CharW-1:0] ChColon    = 8'h3A;
  localparam logic [CharW-1:0] ChQuestion = 8'h3F;
  localparam logic [CharW-1:0] ChDot      = 8'h2E;
  localparam logic [CharW-1:0] ChPercent  = 8'h25;
  localparam logic [CharW-1:0] ChPlus     = 8'h2B;
  localparam logic [CharW-1:0] ChMinus    = 8'h2D;

  typedef enum logic [PhaseW-1:0] {
    PhBegin    = 4'd0,
    PhScheme   = 4'd1,
    PhColon    = 4'd2,
    PhSlash1   = 4'd3,
    PhSlash2   = 4'd4,
    PhHost     = 4'd5,
    PhPort     = 4'd6,
    PhPrePath  = 4'd7,
    PhPath     = 4'd8,
    PhPreExt   = 4'd9,
    PhExt      = 4'd10,
    PhPreQuery = 4'd11,
    PhQuery    = 4'd12
  } phase_e;

  typedef enum logic [MarkW-1:0] {
    MkNone        = 4'd0,
    MkSchemeStart = 4'd1,
    MkSchemeEnd   = 4'd2,
    MkHostStart   = 4'd3,
    MkHostEnd     = 4'd4,
    MkPortEnd     = 4'd5,
    MkPathStart   = 4'd6,
    MkPathEnd     = 4'd7,
    MkExtStart    = 4'd8,
    MkExtEnd      = 4'd9,
    MkQueryStart  = 4'd10
  } mark_e;

  // Result of one character step.
  typedef struct packed {
    logic   bad;
    phase_e phase;
    mark_e  mark;
  } step_t;

  function automatic logic is_alpha(input logic [CharW-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_path(input logic [CharW-1:0] c);
    logic sym;
    case (c)
      ChMinus, 8'h5F, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29, ChPercent,
      ChColon, 8'h40, 8'h26, 8'h3D, ChPlus, 8'h24, 8'h2C, 8'h3B: sym = 1'b1;
      default: sym = 1'b0;
    endcase
    return is_alpha(c) || is_digit(c) || sym;
  endfunction

  function automatic logic is_query(input logic [CharW-1:0] c);
    return c == ChDot || c == ChSlash || c == ChQuestion || is_path(c);
  endfunction

endpackage

// File: rtl/ucp_step.sv
// Combinational phase transition for one URI character.
// Depends on ucp_pkg for phase and mark codes and character classes.
module ucp_step (
  input  logic [ucp_pkg::CharW-1:0] ch_i,
  input  ucp_pkg::phase_e           phase_i,
  input  logic                      err_i,
  output ucp_pkg::step_t            step_o
);

  logic            ok;
  logic            alpha;
  logic            digit;
  ucp_pkg::phase_e ph;
  ucp_pkg::mark_e  mk;

  assign alpha = ucp_pkg::is_alpha(ch_i);
  assign digit = ucp_pkg::is_digit(ch_i);

  always_comb begin
    ok = 1'b1;
    ph = phase_i;
    mk = ucp_pkg::MkNone;
    unique case (phase_i)
      ucp_pkg::PhBegin: begin
        if (ch_i == ucp_pkg::ChSlash) ph = ucp_pkg::PhPrePath;
        else if (alpha) begin
          ph = ucp_pkg::PhScheme;
          mk = ucp_pkg::MkSchemeStart;
        end else ok = 1'b0;
      end
      ucp_pkg::PhScheme: begin
        if (alpha || digit || ch_i == ucp_pkg::ChPlus || ch_i == ucp_pkg::ChMinus ||
            ch_i == ucp_pkg::ChDot) ph = phase_i;
        else if (ch_i == ucp_pkg::ChColon) begin
          ph = ucp_pkg::PhColon;
          mk = ucp_pkg::MkSchemeEnd;
        end else ok = 1'b0;
      end
      ucp_pkg::PhColon: begin
        if (ch_i == ucp_pkg::ChSlash) ph = ucp_pkg::PhSlash1;
        else ok = 1'b0;
      end
      ucp_pkg::PhSlash1: begin
        if (ch_i == ucp_pkg::ChSlash) ph = ucp_pkg::PhSlash2;
        else ok = 1'b0;
      end
      ucp_pkg::PhSlash2: begin
        if (alpha || digit) begin
          ph = ucp_pkg::PhHost;
          mk = ucp_pkg::MkHostStart;
        end else ok = 1'b0;
      end
      ucp_pkg::PhHost: begin
        if (alpha || digit || ch_i == ucp_pkg::ChDot || ch_i == ucp_pkg::ChMinus) ph = phase_i;
        else if (ch_i == ucp_pkg::ChColon) begin
          ph = ucp_pkg::PhPort;
          mk = ucp_pkg::MkHostEnd;
        end else if (ch_i == ucp_pkg::ChSlash) begin
          ph = ucp_pkg::PhPrePath;
          mk = ucp_pkg::MkHostEnd;
        end else ok = 1'b0;
      end
      ucp_pkg::PhPort: begin
        if (digit) ph = phase_i;
        else if (ch_i == ucp_pkg::ChSlash) begin
          ph = ucp_pkg::PhPrePath;
          mk = ucp_pkg::MkPortEnd;
        end else ok = 1'b0;
      end
      ucp_pkg::PhPrePath: begin
        if (ucp_pkg::is_path(ch_i)) begin
          ph = ucp_pkg::PhPath;
          mk = ucp_pkg::MkPathStart;
        end else ok = 1'b0;
      end
      ucp_pkg::PhPath: begin
        // Characters outside the path set, other than dot and question mark, are dropped without an error.
        if (ucp_pkg::is_path(ch_i)) ph = phase_i;
        else if (ch_i == ucp_pkg::ChDot) begin
          ph = ucp_pkg::PhPreExt;
          mk = ucp_pkg::MkPathEnd;
        end else if (ch_i == ucp_pkg::ChQuestion) begin
          ph = ucp_pkg::PhPreQuery;
          mk = ucp_pkg::MkPathEnd;
        end
      end
      ucp_pkg::PhPreExt: begin
        if (alpha) begin
          ph = ucp_pkg::PhExt;
          mk = ucp_pkg::MkExtStart;
        end else ok = 1'b0;
      end
      ucp_pkg::PhExt: begin
        if (alpha) ph = phase_i;
        else if (ch_i == ucp_pkg::ChQuestion) begin
          ph = ucp_pkg::PhPreQuery;
          mk = ucp_pkg::MkExtEnd;
        end else ok = 1'b0;
      end
      ucp_pkg::PhPreQuery: begin
        if (ucp_pkg::is_query(ch_i)) begin
          ph = ucp_pkg::PhQuery;
          mk = ucp_pkg::MkQueryStart;
        end else ok = 1'b0;
      end
      ucp_pkg::PhQuery: begin
        if (!ucp_pkg::is_query(ch_i)) ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
  end

  // A rejected character, or any character after one, keeps the phase and gives no mark.
  always_comb begin
    if (err_i || !ok) begin
      step_o.bad   = 1'b1;
      step_o.phase = phase_i;
      step_o.mark  = ucp_pkg::MkNone;
    end else begin
      step_o.bad   = 1'b0;
      step_o.phase = ph;
      step_o.mark  = mk;
    end
  end

endmodule

// File: rtl/uri_char_parser.sv
// Top level of the URI character parser: input register, parse state,
// position counter and result register around ucp_step.
// Depends on ucp_pkg and ucp_step.
//
//   Channel   Dir  Fields (low bit first)
//   s_axis    in   tdata: ch[7:0]; tuser: start_req
//   m_axis    out  tdata: parse_phase[3:0], mark_kind[7:4], mark_pos[19:8], zero[23:20];
//                  tuser: bad
//
// One character per cycle sustained while m_axis is not stalled. A request is captured in the
// input register when accepted, and its result is then loaded into the result register,
// which raises m_axis_tvalid_o. The parse state is written together with the result
// register, and the next character is evaluated against the updated state. Reset returns
// to the begin phase with position and error cleared.
// A stalled output holds the result and, once the input register is also full,
// s_axis_tready_o drops.
module uri_char_parser #(
  parameter int unsigned MAX_URI_LEN = ucp_pkg::MaxUriLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // ch[7:0]
  input  logic        s_axis_tuser_i,   // start_req
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // parse_phase[3:0], mark_kind[7:4], mark_pos[19:8]
  output logic        m_axis_tuser_o    // bad
);

  localparam int unsigned PosW = ucp_pkg::PosW;
  localparam int unsigned PosMaxInt = (MAX_URI_LEN - 1 < (2 ** PosW) - 1) ?
                                      MAX_URI_LEN - 1 : (2 ** PosW) - 1;
  localparam logic [PosW-1:0] PosMax = PosMaxInt[PosW-1:0];

  // Input register.
  logic                      in_vld_q;
  logic [ucp_pkg::CharW-1:0] ch_q;
  logic                      start_q;

  // Parse state.
  ucp_pkg::phase_e  phase_q, phase_d, phase_eff;
  logic             err_q, err_d, err_eff;
  logic [PosW-1:0]  pos_q, pos_d, pos_eff;

  // Result register.
  logic             out_vld_q;
  ucp_pkg::step_t   res_q;
  logic [PosW-1:0]  mpos_q, mpos_d;

  ucp_pkg::step_t   step;
  logic             out_free;
  logic             proc;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign proc            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;

  assign phase_eff = start_q ? ucp_pkg::PhBegin : phase_q;
  assign err_eff   = start_q ? 1'b0 : err_q;
  assign pos_eff   = start_q ? '0 : pos_q;

  ucp_step u_step (
    .ch_i    (ch_q),
    .phase_i (phase_eff),
    .err_i   (err_eff),
    .step_o  (step)
  );

  assign phase_d = step.phase;
  assign err_d   = step.bad;
  assign pos_d   = (pos_eff < PosMax) ? pos_eff + 1'b1 : pos_eff;
  assign mpos_d  = (step.mark != ucp_pkg::MkNone) ? pos_eff : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= ucp_pkg::PhBegin;
      err_q     <= 1'b0;
      pos_q     <= '0;
    end else begin
      if (s_axis_tready_o) in_vld_q <= s_axis_tvalid_i;
      if (out_free) out_vld_q <= in_vld_q;
      if (proc) begin
        phase_q <= phase_d;
        err_q   <= err_d;
        pos_q   <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      ch_q    <= s_axis_tdata_i;
      start_q <= s_axis_tuser_i;
    end
    if (proc) begin
      res_q  <= step;
      mpos_q <= mpos_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = res_q.bad;
  assign m_axis_tdata_o  = {4'b0000, mpos_q, res_q.mark, res_q.phase};

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax)
    else $error("position counter beyond its limit");

  a_mark_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.mark != ucp_pkg::MkNone |-> !res_q.bad)
    else $error("boundary mark given with error set");

  a_err_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && err_q && !start_q |=> err_q && phase_q == $past(phase_q))
    else $error("phase moved after an error");

  a_no_mark_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.mark == ucp_pkg::MkNone |-> mpos_q == '0)
    else $error("mark position nonzero without a mark");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> pos_q == $past(pos_q))
    else $error("position advanced without a character");
`endif

endmodule
